>>> src/sdpm_pkg.sv
// ----------------------------------------------------------------------------
// sdpm_pkg
// shared types and constants for the sparse dot product merge block
// ----------------------------------------------------------------------------
package sdpm_pkg;

  localparam int DEF_MAX_NNZ = 256;
  localparam int DEF_MAX_DIM = 1024;

  localparam int INDEX_W = 10;
  localparam int VALUE_W = 32;
  localparam int ACC_W   = 64;
  localparam int FRAC_W  = 16;

  // half an lsb of q16.16 in a q32.32 product
  localparam logic signed [ACC_W-1:0] ROUND_HALF = 64'sd32768;
  localparam logic signed [ACC_W-1:0] SUM_MAX    = 64'sd2147483647;
  localparam logic signed [ACC_W-1:0] SUM_MIN    = -64'sd2147483648;

  // list select carried by the kind field
  localparam logic KIND_A = 1'b0;
  localparam logic KIND_B = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_ROUND,
    S_ACC,
    S_DONE
  } state_t;

endpackage

>>> src/sdpm_ram.sv
// ----------------------------------------------------------------------------
// sdpm_ram
// simple dual port ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
module sdpm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/sparse_dot_product_merge.sv
// ----------------------------------------------------------------------------
// sparse_dot_product_merge
// one entry of a sparse matrix product by merge intersection of two lists
// ----------------------------------------------------------------------------
// Send the elements of the A row (kind 0), then the elements of the B column
// (kind 1), each list in ascending index order. Element transactions are
// taken while idle. The B transaction with last set starts the merge walk,
// and the block stalls its input until the result is registered. The walk
// reads one entry of each list ram per step, in a read and a compare state;
// a match adds a round and an accumulate state on the shared multiply, round
// and accumulate path, and a done state saturates and registers the result.
// Every step advances at least one pointer and a match advances both, so the
// walk ends once either list is used up; the done state waits while the
// previous result is held by out_stall. The steps are set by the single
// read port of each list ram and the one multiplier. Elements beyond
// MAX_NNZ per list are dropped and flag overflow; indices at or above
// MAX_DIM are ignored. The result waits in an output register, so the
// next entry can load while it is not yet taken.
module sparse_dot_product_merge import sdpm_pkg::*; #(
  parameter int MAX_NNZ = DEF_MAX_NNZ,
  parameter int MAX_DIM = DEF_MAX_DIM
) (
  input  logic                      clk,
  input  logic                      rst,
  // element transactions
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      kind,
  input  logic [INDEX_W-1:0]        index,
  input  logic signed [VALUE_W-1:0] value,
  input  logic                      last,
  // result transactions
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [VALUE_W-1:0] sum,
  output logic                      nonzero,
  output logic                      overflow
);

  localparam int AW      = (MAX_NNZ > 1) ? $clog2(MAX_NNZ) : 1;
  localparam int CW      = $clog2(MAX_NNZ + 1);
  localparam int ENTRY_W = INDEX_W + VALUE_W;

  state_t state, state_next;

  // list fill counts and walk pointers (wide enough to count to MAX_NNZ)
  logic [CW-1:0] a_count, b_count;
  logic [CW-1:0] ia, ib, ia_next, ib_next;
  logic          overflow_seen;

  logic signed [ACC_W-1:0] prod, term, acc, acc_sat;

  // input side decode
  logic in_acc, index_ok, a_room, b_room, a_we, b_we, start_walk;

  assign in_acc   = in_valid && !in_stall;
  assign index_ok = 32'(index) < MAX_DIM;
  assign a_room   = a_count < CW'(MAX_NNZ);
  assign b_room   = b_count < CW'(MAX_NNZ);
  assign a_we     = in_acc && (kind == KIND_A) && index_ok && a_room;
  assign b_we     = in_acc && (kind == KIND_B) && index_ok && b_room;
  // an empty list skips the walk and goes straight to the result
  assign start_walk = (a_count != '0) && ((b_count != '0) || b_we);

  // list rams: {index, value} per entry
  logic [ENTRY_W-1:0] a_rdata, b_rdata;

  sdpm_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_NNZ)) u_a_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_count[AW-1:0]),
    .wdata ({index, value}),
    .raddr (ia[AW-1:0]),
    .rdata (a_rdata)
  );

  sdpm_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_NNZ)) u_b_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_count[AW-1:0]),
    .wdata ({index, value}),
    .raddr (ib[AW-1:0]),
    .rdata (b_rdata)
  );

  logic [INDEX_W-1:0]        a_idx, b_idx;
  logic signed [VALUE_W-1:0] a_val, b_val;

  assign a_idx = a_rdata[ENTRY_W-1:VALUE_W];
  assign b_idx = b_rdata[ENTRY_W-1:VALUE_W];
  assign a_val = signed'(a_rdata[VALUE_W-1:0]);
  assign b_val = signed'(b_rdata[VALUE_W-1:0]);

  // merge step decision, only meaningful in the compare state
  logic match, a_less, adv_a, adv_b, more_work, out_free;

  always_comb begin
    match     = (a_idx == b_idx);
    a_less    = (a_idx < b_idx);
    adv_a     = (state == S_CMP) && (match || a_less);
    adv_b     = (state == S_CMP) && !a_less;
    ia_next   = ia + CW'(adv_a);
    ib_next   = ib + CW'(adv_b);
    more_work = (ia_next < a_count) && (ib_next < b_count);
  end

  assign out_free = !out_valid || !out_stall;

  // saturate the accumulator to q16.16 range
  always_comb begin
    if (acc > SUM_MAX) begin
      acc_sat = SUM_MAX;
    end else if (acc < SUM_MIN) begin
      acc_sat = SUM_MIN;
    end else begin
      acc_sat = acc;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc && (kind == KIND_B) && last) begin
          state_next = start_walk ? S_READ : S_DONE;
        end
      end
      S_READ: begin
        state_next = S_CMP;
      end
      S_CMP: begin
        if (match) begin
          state_next = S_ROUND;
        end else begin
          state_next = more_work ? S_READ : S_DONE;
        end
      end
      S_ROUND: begin
        state_next = S_ACC;
      end
      S_ACC: begin
        state_next = more_work ? S_READ : S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    case (state)
      S_IDLE:  in_stall = 1'b0;
      default: in_stall = 1'b1;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      a_count       <= '0;
      b_count       <= '0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      // a result taken while a new one is registered is replaced below
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (a_we) begin
            a_count <= a_count + 1'b1;
          end
          if (b_we) begin
            b_count <= b_count + 1'b1;
          end
          // a full list drops the element and remembers it
          if (in_acc && index_ok &&
              (((kind == KIND_A) && !a_room) || ((kind == KIND_B) && !b_room))) begin
            overflow_seen <= 1'b1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            a_count       <= '0;
            b_count       <= '0;
            overflow_seen <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // datapath: pointers, shared multiply / round / accumulate, result register
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        ia  <= '0;
        ib  <= '0;
        acc <= '0;
      end
      S_CMP: begin
        ia <= ia_next;
        ib <= ib_next;
        if (match) begin
          prod <= a_val * b_val;
        end
      end
      S_ROUND: begin
        // round half up: floor of (p + 2^15) / 2^16
        term <= (prod + ROUND_HALF) >>> FRAC_W;
      end
      S_ACC: begin
        acc <= acc + term;
      end
      S_DONE: begin
        if (out_free) begin
          sum      <= acc_sat[VALUE_W-1:0];
          nonzero  <= (acc != '0);
          overflow <= overflow_seen;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> src/sdpm_checker.sv
// ----------------------------------------------------------------------------
// sdpm_checker
// port level checks for the sparse dot product merge block
// ----------------------------------------------------------------------------
module sdpm_checker import sdpm_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      kind,
  input logic                      last,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic signed [VALUE_W-1:0] sum,
  input logic                      nonzero,
  input logic                      overflow
);

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // nonzero flag agrees with the sum
  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (nonzero == (sum != '0)))
    else $error("nonzero flag disagrees with sum");

  // final b element starts the walk, input stalls next cycle
  a_walk_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (kind == KIND_B) && last) |=> in_stall)
    else $error("input not stalled after final b element");

  // loading an a element keeps the input open
  a_load_a: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (kind == KIND_A)) |=> !in_stall)
    else $error("input stalled after a element");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(sum) && $stable(nonzero) && $stable(overflow)))
    else $error("stalled result changed");

endmodule

bind sparse_dot_product_merge sdpm_checker u_sdpm_checker (.*);

>>> verif/tb_sparse_dot_product_merge.sv
// ----------------------------------------------------------------------------
// tb_sparse_dot_product_merge
// self-checking bench for the sparse dot product merge block
// ----------------------------------------------------------------------------
// Element transactions are queued up front by an initial block and fed to the
// block by a burst-and-gap driver. Every accepted element goes through a
// bench-side copy of the two lists. The B element with last set runs the
// merge walk, and the rounded, saturated dot product is queued as the
// expected result. A monitor compares every accepted result, field by field,
// with the oldest queued dot product. The receiver stalls on its own pattern
// and holds off once for a long stretch, so the block fills up and stalls
// its input.
// ----------------------------------------------------------------------------
module tb_sparse_dot_product_merge;
  import sdpm_pkg::*;

  localparam int NNZ            = DEF_MAX_NNZ;
  localparam int DIM            = DEF_MAX_DIM;
  localparam int RANDOM_ITEMS   = 1250;
  localparam int IDLE_LIMIT     = 20000;   // limit well above the worst full-list compute
  localparam int DRAIN_CYCLES   = 100;
  localparam int HOLD_CYCLES    = 600;
  localparam int HOLD_AFTER     = 15;      // results seen before the long hold-off

  localparam logic [VALUE_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
  localparam logic [VALUE_W-1:0] VAL_MIN = 32'h8000_0000;

  typedef struct packed {
    logic               kind;
    logic [INDEX_W-1:0] index;
    logic [VALUE_W-1:0] value;
    logic               last;
  } element_t;

  typedef struct packed {
    logic [VALUE_W-1:0] sum;
    logic               nonzero;
    logic               overflow;
  } dot_result_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  // element channel
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               kind     = 1'b0;
  logic [INDEX_W-1:0] index    = '0;
  logic [VALUE_W-1:0] value    = '0;
  logic               last     = 1'b0;

  // result channel
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [VALUE_W-1:0] sum;
  logic               nonzero;
  logic               overflow;

  // stimulus and expected dot products
  element_t    elements_to_send [$];
  dot_result_t dot_products_due [$];
  int          items_queued = 0;

  // bench copy of the two element lists
  logic [INDEX_W-1:0]        a_index_mem [NNZ];
  logic signed [VALUE_W-1:0] a_value_mem [NNZ];
  logic [INDEX_W-1:0]        b_index_mem [NNZ];
  logic signed [VALUE_W-1:0] b_value_mem [NNZ];
  int                        a_len = 0;
  int                        b_len = 0;
  bit                        elem_dropped = 1'b0;

  // run bookkeeping
  int errors          = 0;
  int items_accepted  = 0;
  int results_checked = 0;
  int dots_predicted  = 0;
  int dots_matched    = 0;
  int dots_saturated  = 0;
  int dots_overflowed = 0;
  int idle_cycles     = 0;

  // driver and receiver state
  bit       in_fire = 1'b0;
  element_t next_elem;
  int       burst_left = 0;
  int       gap_left   = 0;
  int       recv_cycle = 0;
  int       hold_left  = 0;
  bit       held_once  = 1'b0;

  sparse_dot_product_merge u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .index     (index),
    .value     (value),
    .last      (last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sum       (sum),
    .nonzero   (nonzero),
    .overflow  (overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // predictor: store one element, and on a B last run the merge walk
  // --------------------------------------------------------------------------
  task automatic merge_element(input element_t e);
    int                 ia;
    int                 ib;
    int                 match_count;
    logic signed [63:0] prod;
    logic signed [63:0] term;
    logic signed [63:0] acc;
    dot_result_t        r;
    // indices at or above the dimension never reach a list
    if (e.index < DIM) begin
      if (e.kind == KIND_A) begin
        if (a_len >= NNZ) begin
          elem_dropped = 1'b1;
        end else begin
          a_index_mem[a_len] = e.index;
          a_value_mem[a_len] = e.value;
          a_len++;
        end
      end else begin
        if (b_len >= NNZ) begin
          elem_dropped = 1'b1;
        end else begin
          b_index_mem[b_len] = e.index;
          b_value_mem[b_len] = e.value;
          b_len++;
        end
      end
    end
    // last on an A element does nothing more
    if (e.kind == KIND_A || !e.last) return;

    ia = 0;
    ib = 0;
    match_count = 0;
    acc = '0;
    while (ia < a_len && ib < b_len) begin
      if (a_index_mem[ia] == b_index_mem[ib]) begin
        prod = a_value_mem[ia] * b_value_mem[ib];
        // round half up: add half an lsb, then floor by arithmetic shift
        term = (prod + ROUND_HALF) >>> FRAC_W;
        acc += term;
        ia++;
        ib++;
        match_count++;
      end else if (a_index_mem[ia] < b_index_mem[ib]) begin
        ia++;
      end else begin
        ib++;
      end
    end

    if (acc > SUM_MAX) begin
      acc = SUM_MAX;
      dots_saturated++;
    end else if (acc < SUM_MIN) begin
      acc = SUM_MIN;
      dots_saturated++;
    end

    r.sum      = acc[VALUE_W-1:0];
    r.nonzero  = (acc != 0);
    r.overflow = elem_dropped;
    dot_products_due.push_back(r);

    dots_predicted++;
    if (match_count > 0) dots_matched++;
    if (elem_dropped) dots_overflowed++;

    // the block clears both lists after every compute
    a_len = 0;
    b_len = 0;
    elem_dropped = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // stimulus builders
  // --------------------------------------------------------------------------
  task automatic push_elem(input logic k, input int idx, input logic [VALUE_W-1:0] v,
                           input logic l);
    element_t e;
    e.kind  = k;
    e.index = idx[INDEX_W-1:0];
    e.value = v;
    e.last  = l;
    elements_to_send.push_back(e);
    items_queued++;
  endtask

  // mostly small values so sums stay in range, some full-width and corner ones
  function automatic logic [VALUE_W-1:0] pick_value();
    int sel;
    int small_val;
    sel = $urandom_range(0, 9);
    if (sel <= 5) begin
      small_val = int'($urandom_range(0, 524287)) - 262144;
      return small_val;
    end else if (sel <= 7) begin
      return $urandom;
    end else begin
      case ($urandom_range(0, 6))
        0:       return VAL_MAX;
        1:       return VAL_MIN;
        2:       return 32'hFFFF_FFFF;
        3:       return 32'h0000_0000;
        4:       return 32'h0000_8000;
        5:       return 32'h0001_0000;
        default: return 32'h0000_0001;
      endcase
    end
  endfunction

  // well-formed entry: both lists ascending, drawn from one walk so they overlap
  task automatic build_sorted_entry(input int na, input int nb);
    int aq [$];
    int bq [$];
    int pos;
    int choice;
    bit a_last;
    if ($urandom_range(0, 3) == 0) pos = $urandom_range(960, 1023);
    else pos = $urandom_range(0, 960);
    while ((aq.size() < na || bq.size() < nb) && pos <= DIM - 1) begin
      choice = $urandom_range(0, 2);
      if (choice != 1 && aq.size() < na) aq.push_back(pos);
      if (choice != 0 && bq.size() < nb) bq.push_back(pos);
      pos += $urandom_range(1, 3);
    end
    if (bq.size() == 0) bq.push_back(DIM - 1);
    for (int i = 0; i < aq.size(); i++) begin
      if (i == aq.size() - 1) a_last = 1'($urandom_range(0, 1));
      else a_last = ($urandom_range(0, 9) == 0);
      push_elem(KIND_A, aq[i], pick_value(), a_last);
    end
    for (int i = 0; i < bq.size(); i++)
      push_elem(KIND_B, bq[i], pick_value(), i == bq.size() - 1);
  endtask

  // indices in any order from a narrow window so matches still happen
  task automatic build_unordered_entry();
    int na;
    int nb;
    na = $urandom_range(0, 8);
    nb = $urandom_range(1, 8);
    for (int i = 0; i < na; i++)
      push_elem(KIND_A, $urandom_range(0, 15), pick_value(), 1'($urandom_range(0, 1)));
    for (int i = 0; i < nb; i++)
      push_elem(KIND_B, $urandom_range(0, 15), pick_value(), i == nb - 1);
  endtask

  // random kinds and flags, closed by a B last so the lists get flushed
  task automatic build_noise_entry();
    int n;
    n = $urandom_range(1, 10);
    for (int i = 0; i < n; i++)
      push_elem(1'($urandom_range(0, 1)), $urandom_range(0, DIM - 1), pick_value(),
                $urandom_range(0, 6) == 0);
    push_elem(KIND_B, $urandom_range(0, DIM - 1), pick_value(), 1'b1);
  endtask

  // A list two past capacity; the tail is dropped and flags overflow
  task automatic build_full_a_entry();
    for (int i = 0; i < NNZ + 2; i++)
      push_elem(KIND_A, i * 3, pick_value(), i == NNZ + 1);
    push_elem(KIND_B, 3, pick_value(), 1'b0);
    push_elem(KIND_B, 300, pick_value(), 1'b0);
    push_elem(KIND_B, (NNZ - 1) * 3, pick_value(), 1'b1);
  endtask

  // B list past capacity; the dropped B last must still start the compute
  task automatic build_full_b_entry();
    push_elem(KIND_A, 0, pick_value(), 1'b0);
    push_elem(KIND_A, 10, pick_value(), 1'b0);
    push_elem(KIND_A, 200, pick_value(), 1'b0);
    push_elem(KIND_A, 500, pick_value(), 1'b1);
    for (int i = 0; i < NNZ + 3; i++)
      push_elem(KIND_B, i * 2, pick_value(), i == NNZ + 2);
  endtask

  task automatic build_directed();
    // empty A list: sum is zero
    push_elem(KIND_B, 0, VAL_MAX, 1'b1);
    // max times max saturates high
    push_elem(KIND_A, 5, VAL_MAX, 1'b1);
    push_elem(KIND_B, 5, VAL_MAX, 1'b1);
    // min times max saturates low, at the top index
    push_elem(KIND_A, DIM - 1, VAL_MIN, 1'b1);
    push_elem(KIND_B, DIM - 1, VAL_MAX, 1'b1);
    // min times min, plus a zero-valued match
    push_elem(KIND_A, 0, VAL_MIN, 1'b0);
    push_elem(KIND_A, DIM - 1, VAL_MIN, 1'b1);
    push_elem(KIND_B, 0, VAL_MIN, 1'b0);
    push_elem(KIND_B, DIM - 1, 32'h0, 1'b1);
    // rounding at the half point: +1 and -1 cancel, nonzero stays low
    push_elem(KIND_A, 3, 32'h0000_0001, 1'b0);
    push_elem(KIND_A, 9, 32'hFFFF_FFFF, 1'b1);
    push_elem(KIND_B, 3, 32'h0000_8000, 1'b0);
    push_elem(KIND_B, 9, 32'h0000_8001, 1'b1);
    // unordered lists
    push_elem(KIND_A, 20, 32'h0002_0000, 1'b0);
    push_elem(KIND_A, 10, 32'h0003_0000, 1'b1);
    push_elem(KIND_B, 10, 32'hFFFF_0000, 1'b0);
    push_elem(KIND_B, 20, 32'h0000_4000, 1'b1);
    // no matching index
    push_elem(KIND_A, 1, 32'h0001_0000, 1'b1);
    push_elem(KIND_B, 2, 32'h0001_0000, 1'b1);
    // last on an A element in the middle of the list
    push_elem(KIND_A, 4, 32'h0001_8000, 1'b1);
    push_elem(KIND_A, 6, 32'hFFFE_8000, 1'b1);
    push_elem(KIND_B, 6, 32'h0002_0000, 1'b1);
  endtask

  // --------------------------------------------------------------------------
  // driver: bursts of random length with random gaps, changes at falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      // the current transaction is gone, pick what comes next
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (elements_to_send.size() > 0) begin
        next_elem = elements_to_send.pop_front();
        kind     <= next_elem.kind;
        index    <= next_elem.index;
        value    <= next_elem.value;
        last     <= next_elem.last;
        in_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          // a third of the bursts run straight into the next one
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // receiver: stall pattern in phases, plus one long hold-off
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    recv_cycle++;
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!held_once && results_checked >= HOLD_AFTER) begin
      // hold long enough for the output register and the input to back up
      held_once = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      case ((recv_cycle / 300) % 4)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ((recv_cycle % 5) < 3);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // monitor: predict on accepted elements, check accepted results
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    element_t    seen;
    dot_result_t due;
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        seen.kind  = kind;
        seen.index = index;
        seen.value = value;
        seen.last  = last;
        merge_element(seen);
        items_accepted++;
      end
      if (out_valid && !out_stall) begin
        results_checked++;
        if (dot_products_due.size() == 0) begin
          $display("%0t: result with no dot product due, actual sum %0d", $time,
                   $signed(sum));
          errors++;
        end else begin
          due = dot_products_due.pop_front();
          if (sum !== due.sum) begin
            $display("%0t: sum mismatch, expected %0d actual %0d", $time,
                     $signed(due.sum), $signed(sum));
            errors++;
          end
          if (nonzero !== due.nonzero) begin
            $display("%0t: nonzero mismatch, expected %0b actual %0b", $time,
                     due.nonzero, nonzero);
            errors++;
          end
          if (overflow !== due.overflow) begin
            $display("%0t: overflow mismatch, expected %0b actual %0b", $time,
                     due.overflow, overflow);
            errors++;
          end
        end
      end
    end
  end

  // watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("tb_sparse_dot_product_merge failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // sequence: queue everything, release reset, wait for the last result
  // --------------------------------------------------------------------------
  initial begin
    int entry_no;
    int directed_items;
    int sel;
    build_directed();
    directed_items = items_queued;

    // random entries, two of them filling a list past capacity
    entry_no = 0;
    while (items_queued < directed_items + RANDOM_ITEMS) begin
      entry_no++;
      if (entry_no == 6) begin
        build_full_a_entry();
      end else if (entry_no == 40) begin
        build_full_b_entry();
      end else begin
        sel = $urandom_range(0, 9);
        if (sel <= 6) build_sorted_entry($urandom_range(0, 10), $urandom_range(1, 10));
        else if (sel <= 8) build_unordered_entry();
        else build_noise_entry();
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (elements_to_send.size() > 0 || in_valid || dot_products_due.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (dot_products_due.size() > 0) begin
      $display("%0t: %0d dot products never arrived", $time, dot_products_due.size());
      errors++;
    end

    $display("covered %0d elements, %0d of %0d dot products: %0d with matches, %0d saturated,",
             items_accepted, results_checked, dots_predicted, dots_matched, dots_saturated);
    $display("%0d with a full list, one receiver hold-off of %0d cycles, %0d errors",
             dots_overflowed, HOLD_CYCLES, errors);
    if (errors == 0) begin
      $display("tb_sparse_dot_product_merge passed");
    end else begin
      $display("tb_sparse_dot_product_merge failed");
    end
    $finish;
  end

endmodule
